// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/mmss_pkg.sv =====
// Shared constants, codes and types of the melody step sequencer.
// No dependencies.
package mmss_pkg;

   localparam int NOTE_COUNT_DEF = 16;

   localparam int FREQ_W  = 13;
   localparam int DUR_W   = 12;
   localparam int VAL_W   = 7;
   localparam int WNT_W   = 12;
   localparam int GAP_W   = 8;
   localparam int LVL_W   = 16;
   localparam int RATE_W  = 17;
   localparam int TICK_W  = 17;
   localparam int PULSE_W = 16;
   localparam int ANGLE_W = 16;
   localparam int LIDX_W  = 4;

   localparam logic [ANGLE_W-1:0] STEP_DELTA = 16'd4096;
   localparam int                 MS_DIV     = 1000;
   localparam logic [DUR_W-1:0]   DUR_MAX    = 12'd4095;

   localparam logic [GAP_W-1:0]   GAP_RST   = 8'd0;
   localparam logic [LVL_W-1:0]   LVL_RST   = 16'd512;
   localparam logic [RATE_W-1:0]  RATE_RST  = 17'd20000;
   localparam logic [WNT_W-1:0]   WNT_RST   = 12'd1800;

   typedef enum logic [1:0] {
      CSR_GAP   = 2'd0,
      CSR_LEVEL = 2'd1,
      CSR_RATE  = 2'd2,
      CSR_WNT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_MUTE  = 2'd1,
      ACT_DRIVE = 2'd2
   } drive_action_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Note-length divider handshake.
   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] raw;
      logic [WNT_W-1:0] whole;
   } len_req_type;

   typedef struct packed {
      logic             done;
      logic [DUR_W-1:0] length;
   } len_rsp_type;

endpackage

// ===== hdl/motor_melody_step_sequencer.sv =====
// Top level of the melody step sequencer: handshake, sequencer FSM, note RAM.
// Depends on mmss_pkg, mmss_ram, mmss_len.
//
//  channel | dir | group          | beat carries
//  --------+-----+----------------+---------------------------------------------
//  req     | in  | tvalid/tready  | tuser op; tdata index, freq, note value
//  rsp     | out | tvalid/tready  | tuser angle_update; tdata angle..note_index
//  csr     | in  | valid/ready    | csr_index register, csr_wdata value
//
// Tick beat: accept/RAM read, multiply, step update and mute/advance compare
// in S_IDLE, S_MUL, S_STEP and S_FIN. Load beat: S_IDLE, then S_LDIV waits on
// the 13-step divider (a zero note value skips the division), then S_LFIN.
// One beat is in flight at a time; the rsp register lets a new req be taken
// while the previous result still waits. A stalled rsp holds the FSM in its
// last state. Reset is synchronous; config returns to 0/512/20000/1800.
// The note RAM has no reset; entries must be loaded before they are played.
module motor_melody_step_sequencer
   import mmss_pkg::*;
#(
   parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // req: tuser = op; tdata = load_index[3:0], note_freq[16:4],
   //      note_value[23:17]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  logic [23:0]         req_tdata,
   // rsp: tuser = angle_update; tdata = angle[15:0], drive_action[17:16],
   //      q_voltage[33:18], note_index[37:34], zero pad [39:38]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_tuser,
   output logic [39:0]         rsp_tdata,
   // csr write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [RATE_W-1:0]   csr_wdata
);

   localparam int NIDX_W  = $clog2(NOTE_COUNT);
   localparam int ENTRY_W = FREQ_W + DUR_W;
   localparam int PSTEP_W = TICK_W + FREQ_W;       // tick * freq
   localparam int PMUTE_W = DUR_W + FREQ_W;        // dur * freq
   localparam int PADV_W  = DUR_W + 1 + FREQ_W;    // (dur + gap) * freq

   typedef enum logic [2:0] {
      S_IDLE,
      S_LDIV,
      S_LFIN,
      S_MUL,
      S_STEP,
      S_FIN
   } state_type;

   state_type            state_ff, state_in;

   // configuration
   logic [GAP_W-1:0]     gap_ff;
   logic [LVL_W-1:0]     level_ff;
   logic [RATE_W-1:0]    rate_ff;
   logic [WNT_W-1:0]     wnt_ff;

   // sequencer state
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [PULSE_W-1:0]   pulse_ff, pulse_in;
   logic [NIDX_W-1:0]    note_ff, note_in;
   logic [ANGLE_W-1:0]   angle_ff, angle_in;

   // per-beat working registers
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [PSTEP_W-1:0]   pstep_ff, pstep_in;
   logic [PMUTE_W-1:0]   pmute_ff, pmute_in;
   logic [PADV_W-1:0]    padv_ff, padv_in;
   logic                 stepped_ff, stepped_in;
   logic [NIDX_W-1:0]    lidx_ff, lidx_in;
   logic                 lidx_ok_ff, lidx_ok_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_update_ff, rsp_update_in;
   logic [ANGLE_W-1:0]   rsp_angle_ff, rsp_angle_in;
   logic [1:0]           rsp_action_ff, rsp_action_in;
   logic [LVL_W-1:0]     rsp_q_ff, rsp_q_in;
   logic [LIDX_W-1:0]    rsp_note_ff, rsp_note_in;

   // request fields
   logic                 req_op;
   logic [LIDX_W-1:0]    req_load_index;
   logic [FREQ_W-1:0]    req_note_freq;
   logic [VAL_W-1:0]     req_note_value;
   logic                 req_fire;

   logic                 slot_free;
   logic [NIDX_W+LIDX_W-1:0] lidx_ext;
   logic [PADV_W-1:0]    p1000;
   logic                 mute_hit;
   logic                 adv_hit;
   logic [NIDX_W-1:0]    note_next;

   // RAM and divider hookups
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [ENTRY_W-1:0]   ram_rd_data;
   len_req_type          len_req;
   len_rsp_type          len_rsp;

   assign req_op         = req_tuser;
   assign req_load_index = req_tdata[3:0];
   assign req_note_freq  = req_tdata[16:4];
   assign req_note_value = req_tdata[23:17];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // result beat out of the rsp register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_update_ff;
   assign rsp_tdata  = {2'b00, rsp_note_ff, rsp_q_ff, rsp_action_ff, rsp_angle_ff};

   // address of a load, widened or narrowed to the RAM depth
   assign lidx_ext = {{NIDX_W{1'b0}}, req_load_index};

   // note RAM: {freq, duration} per entry
   mmss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NOTE_COUNT)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (lidx_ff),
      .wr_data ({freq_ff, len_rsp.length}),
      .rd_en   (ram_rd_en),
      .rd_addr (note_ff),
      .rd_data (ram_rd_data)
   );

   assign len_req.start = req_fire && (req_op == OP_LOAD);
   assign len_req.raw   = req_note_value;
   assign len_req.whole = wnt_ff;

   mmss_len u_len (
      .clock (clock),
      .reset (reset),
      .req   (len_req),
      .rsp   (len_rsp)
   );

   assign ram_rd_en = req_fire && (req_op == OP_TICK);
   assign ram_wr_en = (state_ff == S_LFIN) && slot_free && lidx_ok_ff;

   // pulse > floor(x / 1000) is the same as x < pulse * 1000
   assign p1000     = PADV_W'(pulse_ff) * PADV_W'(MS_DIV);
   assign mute_hit  = (gap_ff != '0) && (PADV_W'(pmute_ff) < p1000);
   assign adv_hit   = padv_ff < p1000;
   assign note_next = (note_ff == NIDX_W'(NOTE_COUNT - 1)) ? '0 : note_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      pulse_in      = pulse_ff;
      note_in       = note_ff;
      angle_in      = angle_ff;
      freq_in       = freq_ff;
      dur_in        = dur_ff;
      pstep_in      = pstep_ff;
      pmute_in      = pmute_ff;
      padv_in       = padv_ff;
      stepped_in    = stepped_ff;
      lidx_in       = lidx_ff;
      lidx_ok_in    = lidx_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_update_in = rsp_update_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_action_in = rsp_action_ff;
      rsp_q_in      = rsp_q_ff;
      rsp_note_in   = rsp_note_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_LOAD) begin
                  freq_in    = req_note_freq;
                  lidx_in    = lidx_ext[NIDX_W-1:0];
                  lidx_ok_in = int'(req_load_index) < NOTE_COUNT;
                  state_in   = S_LDIV;
               end else begin
                  tick_in  = tick_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_LDIV: begin
            if (len_rsp.done) begin
               state_in = S_LFIN;
            end
         end
         S_LFIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_update_in = 1'b0;
               rsp_angle_in  = angle_ff;
               rsp_action_in = ACT_NONE;
               rsp_q_in      = '0;
               rsp_note_in   = LIDX_W'(note_ff);
               state_in      = S_IDLE;
            end
         end
         S_MUL: begin
            freq_in  = ram_rd_data[ENTRY_W-1:DUR_W];
            dur_in   = ram_rd_data[DUR_W-1:0];
            pstep_in = PSTEP_W'(tick_ff) * PSTEP_W'(ram_rd_data[ENTRY_W-1:DUR_W]);
            pmute_in = PMUTE_W'(ram_rd_data[DUR_W-1:0])
                       * PMUTE_W'(ram_rd_data[ENTRY_W-1:DUR_W]);
            state_in = S_STEP;
         end
         S_STEP: begin
            // zero freq never reaches a nonzero rate; zero rate always steps
            stepped_in = pstep_ff >= PSTEP_W'(rate_ff);
            if (stepped_in) begin
               tick_in = '0;
               if (pulse_ff != '1) begin
                  pulse_in = pulse_ff + 1'b1;
               end
               angle_in = note_ff[0] ? angle_ff - STEP_DELTA : angle_ff + STEP_DELTA;
            end
            padv_in  = (PADV_W'(dur_ff) + PADV_W'(gap_ff)) * PADV_W'(freq_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_update_in = stepped_ff;
               rsp_angle_in  = angle_ff;
               rsp_action_in = ACT_NONE;
               rsp_q_in      = '0;
               rsp_note_in   = LIDX_W'(note_ff);
               if (mute_hit) begin
                  rsp_action_in = ACT_MUTE;
               end
               if (adv_hit) begin
                  rsp_action_in = ACT_DRIVE;
                  rsp_q_in      = level_ff;
                  pulse_in      = '0;
                  note_in       = note_next;
                  rsp_note_in   = LIDX_W'(note_next);
               end
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         pulse_ff     <= '0;
         note_ff      <= '0;
         angle_ff     <= '0;
         gap_ff       <= GAP_RST;
         level_ff     <= LVL_RST;
         rate_ff      <= RATE_RST;
         wnt_ff       <= WNT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         pulse_ff     <= pulse_in;
         note_ff      <= note_in;
         angle_ff     <= angle_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAP:   gap_ff   <= csr_wdata[GAP_W-1:0];
               CSR_LEVEL: level_ff <= csr_wdata[LVL_W-1:0];
               CSR_RATE:  rate_ff  <= csr_wdata;
               CSR_WNT:   wnt_ff   <= csr_wdata[WNT_W-1:0];
               default:   gap_ff   <= gap_ff;
            endcase
         end
      end
      // working and result payload registers, no reset needed
      freq_ff       <= freq_in;
      dur_ff        <= dur_in;
      pstep_ff      <= pstep_in;
      pmute_ff      <= pmute_in;
      padv_ff       <= padv_in;
      stepped_ff    <= stepped_in;
      lidx_ff       <= lidx_in;
      lidx_ok_ff    <= lidx_ok_in;
      rsp_update_ff <= rsp_update_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_action_ff <= rsp_action_in;
      rsp_q_ff      <= rsp_q_in;
      rsp_note_ff   <= rsp_note_in;
   end

endmodule

// ===== hdl/mmss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mmss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmss_len.sv =====
// Note-length unit: whole_note_ticks over the note value, 3/2 for dotted,
// restoring division one quotient bit per cycle. Depends on mmss_pkg.
module mmss_len
   import mmss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  len_req_type req,
   output len_rsp_type rsp
);

   localparam int DVD_W = WNT_W + 1;      // 3/2 of whole fits 13 bits
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [VAL_W-1:0]   rem_ff, rem_in;
   logic [VAL_W-1:0]   dvs_ff, dvs_in;
   logic [DUR_W-1:0]   len_ff, len_in;

   logic [DVD_W:0]     whole3;
   logic [VAL_W:0]     trial;
   logic               ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      len_in  = len_ff;

      whole3 = {2'b00, req.whole} + {1'b0, req.whole, 1'b0};
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dvs_ff};

      if (req.start) begin
         rem_in = '0;
         cnt_in = CNT_W'(DVD_W);
         if (req.raw == '0) begin
            done_in = 1'b1;
            len_in  = '0;
         end else if (!req.raw[VAL_W-1]) begin
            busy_in = 1'b1;
            dvs_in  = req.raw;
            quo_in  = {1'b0, req.whole};
         end else begin
            busy_in = 1'b1;
            // magnitude of a negative value; -64 gives 64
            dvs_in  = VAL_W'(9'd128 - {2'b00, req.raw});
            quo_in  = whole3[DVD_W:1];
         end
      end else if (busy_ff) begin
         rem_in = ge ? VAL_W'(trial - {1'b0, dvs_ff}) : trial[VAL_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            len_in  = quo_in[DVD_W-1] ? DUR_MAX : quo_in[DUR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      len_ff <= len_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.length = len_ff;

endmodule

// ===== hdl/mmss_chk.sv =====
// Port-level checker for the melody step sequencer, bound to the top level.
// Depends on mmss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmss_chk
   import mmss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic [39:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [16:0] csr_wdata
);

   // a stalled result beat keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one beat in flight: the input closes right after an accept
   `ASSERT_NEXT(a_one_beat, clock, reset, req_tvalid && req_tready, !req_tready)

   // q voltage is driven only with the apply-drive action
   `ASSERT_IMPL(a_q_zero, clock, reset, rsp_tvalid && (rsp_tdata[17:16] != ACT_DRIVE), rsp_tdata[33:18] == '0)

   // no result survives reset
   `ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind motor_melody_step_sequencer mmss_chk u_mmss_chk (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for motor_melody_step_sequencer: note loads and ticks
// are checked against an in-bench tone predictor. Depends on mmss_pkg and the RTL.
module tb_top
   import mmss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;  // cycles with no beat on any channel
   localparam int PHASES      = 5;
   localparam int PHASE_BEATS = 250;

   typedef enum logic [1:0] {ROW_TICK, ROW_LOAD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   // One result beat as the block reports it.
   typedef struct packed {
      logic             stepped;
      logic [15:0]      angle;
      drive_action_type action;
      logic [15:0]      q_volt;
      logic [3:0]       note;
   } tone_out_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type csr_sel;
      logic [16:0]   wdata;
      logic [3:0]    idx;
      logic [12:0]   freq;
      logic [6:0]    value;
      logic          typed;  // result after reset is all zeros
   } intro_row_type;

   // Directed opening: reset-state loads, saturated and dotted lengths, then a
   // short song: step, mute, advance, a zero-frequency stall, and a zero loop
   // rate that lets even a silent note step.
   localparam int INTRO_ROWS = 30;
   localparam intro_row_type INTRO [INTRO_ROWS] = '{
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd2,  13'd1,    -7'sd1,  1'b1},
      '{ROW_CSR,  CSR_WNT,   17'd4095,  4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd3,  13'd1,    -7'sd1,  1'b1},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd4,  13'd2,    7'sd1,   1'b1},
      '{ROW_CSR,  CSR_WNT,   17'd2,     4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_CSR,  CSR_GAP,   17'd1,     4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_CSR,  CSR_RATE,  17'd3,     4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_CSR,  CSR_LEVEL, 17'h08000, 4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd0,  13'd1000, 7'sd0,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd1,  13'd0,    -7'sd2,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd15, 13'd8191, 7'sd32,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd5,  13'd4095, -7'sd32, 1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd6,  13'd2048, 7'sd2,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd7,  13'd1,    -7'sd3,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd8,  13'd100,  7'sd4,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd9,  13'd7,    7'sd8,   1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd10, 13'd6000, -7'sd8,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd11, 13'd333,  7'sd16,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd12, 13'd5461, -7'sd16, 1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd13, 13'd2730, 7'sd31,  1'b0},
      '{ROW_LOAD, CSR_GAP,   17'd0,     4'd14, 13'd12,   7'sd3,   1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'hF,  13'h1FFF, -7'sd32, 1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'h0,  13'h0,    7'sd0,   1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'h5,  13'h0AAA, 7'sd21,  1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'hA,  13'h1555, -7'sd11, 1'b0},
      '{ROW_CSR,  CSR_RATE,  17'd0,     4'd0,  13'd0,    7'sd0,   1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'h3,  13'h0123, 7'sd5,   1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'hC,  13'h1ABC, -7'sd7,  1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'h6,  13'h0F0F, 7'sd9,   1'b0},
      '{ROW_TICK, CSR_GAP,   17'd0,     4'h9,  13'h10F0, -7'sd1,  1'b0}
   };

   // Random phases: register settings, extremes among them, and idle pattern.
   localparam int PH_GAP   [PHASES] = '{0, 255, 0, 10, 1};
   localparam int PH_LEVEL [PHASES] = '{32767, 256, -1, 0, 0};  // last two random
   localparam int PH_RATE  [PHASES] = '{1, 100, 100000, 0, 300};
   localparam int PH_WNT   [PHASES] = '{1, 16, 1, 4095, 60};
   localparam idle_mode_type PH_MODE [PHASES] =
      '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;     // op
   logic [23:0] req_tdata = '0;       // load_index, note_freq, note_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;            // angle_update
   logic [39:0] rsp_tdata;            // angle, drive_action, q_voltage, note_index, pad
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   // Predictor state and its copy of the registers.
   logic [7:0]  cfg_gap   = GAP_RST;
   logic [15:0] cfg_level = LVL_RST;
   logic [16:0] cfg_rate  = RATE_RST;
   logic [11:0] cfg_wnt   = WNT_RST;
   logic [16:0] tick_cnt  = '0;
   logic [15:0] pulse_cnt = '0;
   logic [3:0]  cur_note  = '0;
   logic [15:0] rotor     = '0;
   logic [12:0] freq_tab [16];
   logic [11:0] dur_tab  [16];

   tone_out_type tones_due [$];
   int           tone_errors = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           quiet_cycles = 0;

   always #1 clock = ~clock;

   motor_melody_step_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Note length in duration units; negative value = dotted, saturates at 4095.
   function automatic int tone_len(input logic [6:0] raw);
      int d;
      if (raw == '0) return 0;
      if (!raw[6]) d = int'(cfg_wnt) / int'(raw);
      else d = (int'(cfg_wnt) * 3 / 2) / (128 - int'(raw));
      return (d > 4095) ? 4095 : d;
   endfunction

   // Advances the predicted sequencer by one accepted beat.
   task automatic next_tone(input logic op, input logic [3:0] idx, input logic [12:0] freq,
                            input logic [6:0] value, output tone_out_type r);
      logic [3:0]  n;
      logic [12:0] f;
      logic [11:0] dur;
      r = '0;
      if (op == OP_LOAD) begin
         freq_tab[idx] = freq;
         dur_tab[idx]  = 12'(tone_len(value));
      end else begin
         n   = cur_note;
         f   = freq_tab[n];
         dur = dur_tab[n];
         tick_cnt = tick_cnt + 1'b1;
         // zero loop rate steps on every tick, even for a silent note
         if (f != '0 || cfg_rate == '0) begin
            if (longint'(tick_cnt) * longint'(f) >= longint'(cfg_rate)) begin
               tick_cnt = '0;
               if (pulse_cnt != 16'hFFFF) pulse_cnt = pulse_cnt + 1'b1;
               rotor = n[0] ? rotor - STEP_DELTA : rotor + STEP_DELTA;
               r.stepped = 1'b1;
            end
         end
         if (cfg_gap != '0 && longint'(pulse_cnt) > (longint'(dur) * f) / MS_DIV)
            r.action = ACT_MUTE;
         // advance wins over mute
         if (longint'(pulse_cnt) > ((longint'(dur) + cfg_gap) * f) / MS_DIV) begin
            r.action  = ACT_DRIVE;
            r.q_volt  = cfg_level;
            pulse_cnt = '0;
            cur_note  = n + 1'b1;
         end
      end
      r.angle = rotor;
      r.note  = cur_note;
   endtask

   // Note content that keeps notes short enough to move through the song.
   task automatic pick_note(output logic [12:0] f, output logic [6:0] v);
      int span;
      int fmin;
      int fmax;
      v = 7'($urandom_range(64) - 32);
      fmin = (int'(cfg_rate) + 3) / 4;
      if (fmin < 1) fmin = 1;
      if (fmin > 8191) fmin = 8191;
      span = tone_len(v) + int'(cfg_gap);
      fmax = (span == 0) ? 8191 : 12000 / span;
      if (fmax > 8191) fmax = 8191;
      if (fmax < fmin) fmax = fmin;
      f = ($urandom_range(19) == 0) ? 13'd0 : 13'($urandom_range(fmax, fmin));
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 75; recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;  recv_stall_pct = 75;
         end
         default: begin
            send_idle_pct = 8;  recv_stall_pct = 8;
         end
      endcase
   endtask

   // Drives one req beat at the falling edge; predicts it once accepted.
   task automatic send_req(input logic op, input logic [3:0] idx, input logic [12:0] freq,
                           input logic [6:0] value, input logic typed);
      tone_out_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat ($urandom_range(5)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, freq, idx};
      do @(posedge clock); while (!req_tready);
      next_tone(op, idx, freq, value, r);
      tones_due.push_back(typed ? tone_out_type'('0) : r);
   endtask

   // Sender pauses until every predicted tone has come back.
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (tones_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [16:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_GAP:   cfg_gap   = data[7:0];
         CSR_LEVEL: cfg_level = data[15:0];
         CSR_RATE:  cfg_rate  = data;
         CSR_WNT:   cfg_wnt   = data[11:0];
         default:   cfg_gap   = cfg_gap;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Receiver back-pressure, redrawn each falling edge.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Result checker: each rsp beat against the oldest prediction.
   always @(posedge clock) begin
      tone_out_type got;
      tone_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.stepped = rsp_tuser;
         got.angle   = rsp_tdata[15:0];
         got.action  = drive_action_type'(rsp_tdata[17:16]);
         got.q_volt  = rsp_tdata[33:18];
         got.note    = rsp_tdata[37:34];
         if (tones_due.size() == 0) begin
            tone_errors++;
            if (tone_errors <= 10)
               $display("%0t: rsp beat with nothing pending: %s%0b %s%h %s%0d %s%h %s%0d",
                        $realtime, "step=", got.stepped, "angle=", got.angle,
                        "act=", got.action, "q=", got.q_volt, "note=", got.note);
         end else begin
            want = tones_due.pop_front();
            if (got != want) begin
               tone_errors++;
               if (tone_errors <= 10)
                  $display("%0t: tone mismatch want %0b/%h/%0d/%h/%0d got %0b/%h/%0d/%h/%0d",
                           $realtime, want.stepped, want.angle, want.action, want.q_volt,
                           want.note, got.stepped, got.angle, got.action, got.q_volt,
                           got.note);
            end
         end
      end
   end

   // Watchdog: counts cycles in which no channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int          ph;
      int          k;
      logic [3:0]  idx;
      logic [12:0] f;
      logic [6:0]  v;
      logic [15:0] lvl;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed opening
      for (k = 0; k < INTRO_ROWS; k++) begin
         case (INTRO[k].kind)
            ROW_CSR: begin
               settle();
               write_reg(INTRO[k].csr_sel, INTRO[k].wdata);
            end
            ROW_LOAD: send_req(OP_LOAD, INTRO[k].idx, INTRO[k].freq, INTRO[k].value,
                               INTRO[k].typed);
            default:  send_req(OP_TICK, INTRO[k].idx, INTRO[k].freq, INTRO[k].value, 1'b0);
         endcase
      end

      // random songs: fresh registers, a full table load, then mostly ticks
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         lvl = (ph < 3) ? 16'(PH_LEVEL[ph]) : 16'($urandom_range(65535));
         write_reg(CSR_GAP,   17'(PH_GAP[ph]));
         write_reg(CSR_LEVEL, {1'b0, lvl});
         write_reg(CSR_RATE,  17'(PH_RATE[ph]));
         write_reg(CSR_WNT,   17'(PH_WNT[ph]));
         set_idle(PH_MODE[ph]);
         for (k = 0; k < 16; k++) begin
            pick_note(f, v);
            send_req(OP_LOAD, 4'(k), f, v, 1'b0);
         end
         for (k = 0; k < PHASE_BEATS; k++) begin
            if ($urandom_range(99) == 0) settle();
            if ($urandom_range(99) < 15) begin
               // half the reloads hit the playing note, which also frees a stall
               idx = $urandom_range(1) ? cur_note : 4'($urandom_range(15));
               pick_note(f, v);
               send_req(OP_LOAD, idx, f, v, 1'b0);
            end else begin
               send_req(OP_TICK, 4'($urandom), 13'($urandom), 7'($urandom), 1'b0);
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (tone_errors == 0 && tones_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
